### rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_HOLD(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/tmls_pkg.sv
// Package with the widths, limits and register indexes of the mip level selector.
`timescale 1ns / 1ps
package tmls_pkg;
   localparam int COORD_W  = 32;
   localparam int RADIUS_W = 32;
   localparam int FACTOR_W = 24;
   localparam int SCREEN_W = 15;
   localparam int DROP_W   = 4;
   localparam int MIPS_W   = 5;
   localparam int DIST_W   = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 15;
   localparam int LIMB_W   = 32;

   localparam logic [MIPS_W-1:0] MIPS_MAX = 5'd11;
   localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = 15'd1920;
   localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = 15'd1080;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_QUALITY_DROP  = 2'd2
   } csr_addr_type;
endpackage

### rtl/tmls_if.sv
// Channel interfaces for requests, responses and register writes.
`timescale 1ns / 1ps
interface tmls_req_if;
   logic valid;
   logic ready;
   logic signed [tmls_pkg::COORD_W-1:0] viewer_x;
   logic signed [tmls_pkg::COORD_W-1:0] viewer_y;
   logic signed [tmls_pkg::COORD_W-1:0] viewer_z;
   logic signed [tmls_pkg::COORD_W-1:0] center_x;
   logic signed [tmls_pkg::COORD_W-1:0] center_y;
   logic signed [tmls_pkg::COORD_W-1:0] center_z;
   logic [tmls_pkg::RADIUS_W-1:0] sphere_radius;
   logic [tmls_pkg::FACTOR_W-1:0] texel_factor;
   modport source (output valid, viewer_x, viewer_y, viewer_z, center_x, center_y, center_z,
                   sphere_radius, texel_factor, input ready);
   modport sink (input valid, viewer_x, viewer_y, viewer_z, center_x, center_y, center_z,
                 sphere_radius, texel_factor, output ready);
endinterface

interface tmls_rsp_if;
   logic valid;
   logic ready;
   logic signed [tmls_pkg::MIPS_W-1:0] mip_levels;
   logic [tmls_pkg::DIST_W-1:0] view_distance;
   modport source (output valid, mip_levels, view_distance, input ready);
   modport sink (input valid, mip_levels, view_distance, output ready);
endinterface

interface tmls_csr_if;
   logic valid;
   logic ready;
   logic [tmls_pkg::CSR_ADDR_W-1:0] addr;
   logic [tmls_pkg::CSR_DATA_W-1:0] wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

### rtl/tmls_mul.sv
// Two-stage multiplier built from registered limb products and a registered sum.
`timescale 1ns / 1ps
module tmls_mul #(
   parameter int A_W = 32,
   parameter int B_W = 32
) (
   input  logic               clock,
   input  logic               en,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0] p
);
   localparam int LW  = tmls_pkg::LIMB_W;
   localparam int NA  = (A_W + LW - 1) / LW;
   localparam int NB  = (B_W + LW - 1) / LW;
   localparam int PAW = NA * LW;
   localparam int PBW = NB * LW;
   localparam int FW  = PAW + PBW;

   logic [PAW-1:0] a_ext;
   logic [PBW-1:0] b_ext;
   logic [2*LW-1:0] pp_ff [NA*NB];
   logic [FW-1:0] acc;
   logic [A_W+B_W-1:0] p_in;
   logic [A_W+B_W-1:0] p_ff;

   assign a_ext = PAW'(a);
   assign b_ext = PBW'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i*NB+j] <= (2*LW)'(a_ext[i*LW +: LW]) * (2*LW)'(b_ext[j*LW +: LW]);
            end
         end
      end
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            acc = acc + (FW'(pp_ff[i*NB+j]) << (LW * (i + j)));
         end
      end
      p_in = acc[A_W+B_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;
endmodule

### rtl/tmls_isqrt.sv
// Pipelined integer square root that settles one result bit per stage.
`timescale 1ns / 1ps
module tmls_isqrt #(
   parameter int IN_W = 66
) (
   input  logic                clock,
   input  logic                en,
   input  logic [IN_W-1:0]     rad,
   output logic [IN_W/2-1:0]   root
);
   localparam int OUT_W = IN_W / 2;
   localparam int RW    = OUT_W + 3;

   logic [IN_W-1:0]  rad_ff  [OUT_W];
   logic [RW-1:0]    rem_ff  [OUT_W];
   logic [OUT_W-1:0] root_ff [OUT_W];

   for (genvar s = 0; s < OUT_W; s++) begin : g_stage
      logic [IN_W-1:0]  rad_prev;
      logic [RW-1:0]    rem_prev;
      logic [OUT_W-1:0] root_prev;
      logic [RW-1:0]    rem_sh;
      logic [RW-1:0]    trial;
      logic [RW-1:0]    rem_in;
      logic             take;

      if (s == 0) begin : g_first
         assign rad_prev  = rad;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
      end

      assign rem_sh = {rem_prev[RW-3:0], rad_prev[IN_W-1 -: 2]};
      assign trial  = {1'b0, root_prev, 2'b01};
      assign take   = (rem_sh >= trial);
      assign rem_in = take ? (rem_sh - trial) : rem_sh;

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= rad_prev << 2;
            rem_ff[s]  <= rem_in;
            root_ff[s] <= {root_prev[OUT_W-2:0], take};
         end
      end
   end

   assign root = root_ff[OUT_W-1];
endmodule

### rtl/texture_mip_level_select.sv
// Top level of the bounding-sphere texture mip level selector.
//
// Requests arrive on req_chan, one object per transfer: viewer position,
// sphere center and radius in Q16.16, and a texel density factor. Each
// request yields exactly one transfer on rsp_chan with the mip level count
// (after the quality drop) and the view distance, in request order.
// Screen width, screen height and quality drop are to be written on
// csr_chan by the user only while no request is in flight; the block
// itself does not enforce this. csr_chan is always ready. The pipeline
// is 45 stages deep: four stages of differences and squares, 33 stages
// of the square root (one root bit per stage), then products, the exact
// size test and the output register. A new request is taken every cycle
// unless the receiver stalls with a response waiting.
// When the receiver stalls with a response waiting, the whole pipeline
// holds and req_chan.ready drops in the same cycle, so nothing is lost or
// repeated. Synchronous reset empties the pipeline and restores the
// register defaults; there is no clearing pass.
`timescale 1ns / 1ps
module texture_mip_level_select #(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   tmls_req_if.sink   req_chan,
   tmls_rsp_if.source rsp_chan,
   tmls_csr_if.sink   csr_chan
);
   localparam logic [tmls_pkg::FACTOR_W-1:0] FACTOR_FLOOR =
      tmls_pkg::FACTOR_W'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

   localparam int DIFF_W = tmls_pkg::COORD_W + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int ROOT_W = SQ_W / 2;
   localparam int D_W    = ROOT_W + 1;
   localparam int MF_W   = tmls_pkg::SCREEN_W + tmls_pkg::FACTOR_W;
   localparam int P_W    = MF_W + D_W;
   localparam int R2_W   = 2 * tmls_pkg::RADIUS_W;
   localparam int D2_W   = 2 * D_W;
   localparam int P2_W   = 2 * P_W;
   localparam int Q_W    = R2_W + D2_W;
   localparam int NK     = 10;
   localparam int CMP_W  = Q_W + 2 * NK;
   localparam int SB_N   = 4 + ROOT_W;
   localparam int TL_N   = 7;
   localparam int N_STG  = SB_N + 1 + 2 + 1 + 2 + 1 + 1;

   typedef struct packed {
      logic [tmls_pkg::RADIUS_W-1:0] radius;
      logic [MF_W-1:0]               mf;
   } side_type;

   typedef struct packed {
      logic [tmls_pkg::DIST_W-1:0] dist_sat;
      logic                        full;
   } tail_type;

   logic [tmls_pkg::SCREEN_W-1:0] width_ff;
   logic [tmls_pkg::SCREEN_W-1:0] height_ff;
   logic [tmls_pkg::DROP_W-1:0]   drop_ff;

   logic adv;
   logic vld_ff [N_STG];

   logic [DIFF_W:0] diff_x, diff_y, diff_z;
   logic [DIFF_W-1:0] dx_in, dy_in, dz_in;
   logic [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [tmls_pkg::SCREEN_W-1:0] m_in;
   logic [tmls_pkg::FACTOR_W-1:0] ff_in;
   logic [MF_W-1:0] mf_in;
   side_type sb_ff [SB_N];

   logic [SQ_W-1:0] sqx, sqy, sqz;
   logic [SQ_W-1:0] sum_ff;
   logic [ROOT_W-1:0] root;

   side_type sb_last;
   logic [D_W-1:0] d_in;
   logic [D_W-1:0] d_ff;
   logic [tmls_pkg::RADIUS_W-1:0] r38_ff;
   logic [MF_W-1:0] mf38_ff;
   tail_type tail_in;
   tail_type tl_ff [TL_N];

   logic [P_W-1:0]  p40;
   logic [R2_W-1:0] r2_40;
   logic [D2_W-1:0] d2_40;
   logic [P_W-1:0]  p41_ff;
   logic [R2_W-1:0] r2_41_ff;
   logic [D2_W-1:0] e_ff;

   logic [P2_W-1:0] p2_43;
   logic [Q_W-1:0]  q_43;
   logic [NK:0]     le_in;
   logic [NK:0]     le_ff;

   logic [tmls_pkg::MIPS_W-1:0] mips_lvl;
   logic [tmls_pkg::MIPS_W-1:0] mips_in;
   logic [tmls_pkg::MIPS_W-1:0] mips_ff;
   logic [tmls_pkg::DIST_W-1:0] dist_ff;

   // Register writes.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tmls_pkg::SCREEN_WIDTH_RESET;
         height_ff <= tmls_pkg::SCREEN_HEIGHT_RESET;
         drop_ff   <= '0;
      end else if (csr_chan.valid) begin
         case (tmls_pkg::csr_addr_type'(csr_chan.addr))
            tmls_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_chan.wdata;
            tmls_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_chan.wdata;
            tmls_pkg::CSR_QUALITY_DROP:  drop_ff   <= csr_chan.wdata[tmls_pkg::DROP_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline control: every stage moves together unless the output is held.
   assign adv = !vld_ff[N_STG-1] || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N_STG; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_chan.valid;
         for (int i = 1; i < N_STG; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // Absolute differences and the screen-factor product.
   assign diff_x = {{2{req_chan.viewer_x[31]}}, req_chan.viewer_x}
                 - {{2{req_chan.center_x[31]}}, req_chan.center_x};
   assign diff_y = {{2{req_chan.viewer_y[31]}}, req_chan.viewer_y}
                 - {{2{req_chan.center_y[31]}}, req_chan.center_y};
   assign diff_z = {{2{req_chan.viewer_z[31]}}, req_chan.viewer_z}
                 - {{2{req_chan.center_z[31]}}, req_chan.center_z};
   assign dx_in = diff_x[DIFF_W] ? DIFF_W'(-diff_x) : diff_x[DIFF_W-1:0];
   assign dy_in = diff_y[DIFF_W] ? DIFF_W'(-diff_y) : diff_y[DIFF_W-1:0];
   assign dz_in = diff_z[DIFF_W] ? DIFF_W'(-diff_z) : diff_z[DIFF_W-1:0];
   assign m_in  = (width_ff > height_ff) ? width_ff : height_ff;
   assign ff_in = (req_chan.texel_factor > FACTOR_FLOOR) ? req_chan.texel_factor
                                                          : FACTOR_FLOOR;
   assign mf_in = MF_W'(m_in) * MF_W'(ff_in);

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
         sb_ff[0] <= '{radius: req_chan.sphere_radius, mf: mf_in};
         for (int i = 1; i < SB_N; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
      end
   end

   tmls_mul #(.A_W(DIFF_W), .B_W(DIFF_W)) u_sq_x (
      .clock(clock), .en(adv), .a(dx_ff), .b(dx_ff), .p(sqx));
   tmls_mul #(.A_W(DIFF_W), .B_W(DIFF_W)) u_sq_y (
      .clock(clock), .en(adv), .a(dy_ff), .b(dy_ff), .p(sqy));
   tmls_mul #(.A_W(DIFF_W), .B_W(DIFF_W)) u_sq_z (
      .clock(clock), .en(adv), .a(dz_ff), .b(dz_ff), .p(sqz));

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sqx + sqy + sqz;
      end
   end

   tmls_isqrt #(.IN_W(SQ_W)) u_isqrt (
      .clock(clock), .en(adv), .rad(sum_ff), .root(root));

   // View distance and the inside-sphere test.
   assign sb_last = sb_ff[SB_N-1];
   assign d_in = D_W'(root) + D_W'(sb_last.radius >> 2);
   assign tail_in.dist_sat = (d_in[D_W-1:tmls_pkg::DIST_W] != '0) ? '1
                                                                  : d_in[tmls_pkg::DIST_W-1:0];
   assign tail_in.full = !((d_in > D_W'(sb_last.radius)) && (sb_last.radius != '0));

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff    <= d_in;
         r38_ff  <= sb_last.radius;
         mf38_ff <= sb_last.mf;
         tl_ff[0] <= tail_in;
         for (int i = 1; i < TL_N; i++) begin
            tl_ff[i] <= tl_ff[i-1];
         end
      end
   end

   tmls_mul #(.A_W(MF_W), .B_W(D_W)) u_p (
      .clock(clock), .en(adv), .a(mf38_ff), .b(d_ff), .p(p40));
   tmls_mul #(.A_W(tmls_pkg::RADIUS_W), .B_W(tmls_pkg::RADIUS_W)) u_r2 (
      .clock(clock), .en(adv), .a(r38_ff), .b(r38_ff), .p(r2_40));
   tmls_mul #(.A_W(D_W), .B_W(D_W)) u_d2 (
      .clock(clock), .en(adv), .a(d_ff), .b(d_ff), .p(d2_40));

   always_ff @(posedge clock) begin
      if (adv) begin
         p41_ff   <= p40;
         r2_41_ff <= r2_40;
         e_ff     <= d2_40 - D2_W'(r2_40);
      end
   end

   tmls_mul #(.A_W(P_W), .B_W(P_W)) u_p2 (
      .clock(clock), .en(adv), .a(p41_ff), .b(p41_ff), .p(p2_43));
   tmls_mul #(.A_W(R2_W), .B_W(D2_W)) u_q (
      .clock(clock), .en(adv), .a(r2_41_ff), .b(e_ff), .p(q_43));

   // Exact size test against every power of four.
   always_comb begin
      for (int k = 0; k <= NK; k++) begin
         le_in[k] = CMP_W'(p2_43) <= (CMP_W'(q_43) << (2 * k));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         le_ff <= le_in;
      end
   end

   always_comb begin
      mips_lvl = tmls_pkg::MIPS_MAX;
      if (!tl_ff[TL_N-1].full) begin
         for (int k = NK; k >= 0; k--) begin
            if (le_ff[k]) begin
               mips_lvl = tmls_pkg::MIPS_W'(k + 1);
            end
         end
      end
      mips_in = mips_lvl - tmls_pkg::MIPS_W'(drop_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mips_ff <= mips_in;
         dist_ff <= tl_ff[TL_N-1].dist_sat;
      end
   end

   assign rsp_chan.valid         = vld_ff[N_STG-1];
   assign rsp_chan.mip_levels    = mips_ff;
   assign rsp_chan.view_distance = dist_ff;
endmodule

### rtl/tmls_checker.sv
// Port-level checker for the mip level selector and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tmls_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [tmls_pkg::MIPS_W-1:0] mip_levels,
   input logic [tmls_pkg::DIST_W-1:0] view_distance
);
   `ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid && $stable(mip_levels) && $stable(view_distance))
   `ASSERT_HOLD(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready)
   `ASSERT_HOLD(a_empty_after_reset, $past(reset), !rsp_valid)
   `ASSERT_HOLD(a_mips_bound, rsp_valid && req_valid, mip_levels <= $signed(tmls_pkg::MIPS_MAX))
endmodule

bind texture_mip_level_select tmls_checker u_tmls_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .mip_levels(rsp_chan.mip_levels),
   .view_distance(rsp_chan.view_distance)
);
